// ----- sv/chained_page_flash_appender_defines.svh -----
// ----------------------------------------------------------------------------
// Chained page flash appender: assertion macros
// Shared helpers for the concurrent checks on the appender's ports.
// ----------------------------------------------------------------------------
`ifndef CHAINED_PAGE_FLASH_APPENDER_DEFINES_SVH
`define CHAINED_PAGE_FLASH_APPENDER_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define CPFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define CPFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/cpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Chained page flash appender: package
// Widths, codes, constants and payload types shared by all appender modules.
// ----------------------------------------------------------------------------
package cpfa_pkg;

  localparam int unsigned ADDR_W  = 19;
  localparam int unsigned END_W   = 20;
  localparam int unsigned CMP_W   = 21;
  localparam int unsigned NEED_W  = 12;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned LEN_W   = 9;

  localparam int unsigned PAGE_BYTES_DEF  = 1024;
  localparam int unsigned FLASH_BYTES_DEF = 327680;

  localparam logic [ADDR_W-1:0] DICT_PTR_RST = 19'h0B600;
  localparam logic [ADDR_W-1:0] CODE_PTR_RST = 19'h0BA00;

  localparam logic [WORD_W-1:0] END_MARK = 32'h000F_FFFF;
  localparam logic [KEY_W-1:0]  KEY_A    = 16'hA442;
  localparam logic [KEY_W-1:0]  KEY_B    = 16'h71D5;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    OP_APPEND     = 2'd0,
    OP_SET_PTR    = 2'd1,
    OP_ERASE_PAGE = 2'd2,
    OP_ERASE_ALL  = 2'd3
  } op_e;

  typedef enum logic {
    REG_DICT = 1'b0,
    REG_CODE = 1'b1
  } region_e;

  typedef enum logic [1:0] {
    CMD_PROGRAM    = 2'd0,
    CMD_ERASE_PAGE = 2'd1,
    CMD_ERASE_ALL  = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FLT_NONE      = 2'd0,
    FLT_UNALIGNED = 2'd1,
    FLT_TOO_LONG  = 2'd2,
    FLT_FULL      = 2'd3
  } fault_e;

  // Classification of an item, decided by the front end.
  typedef enum logic [2:0] {
    CLS_APPEND,
    CLS_APPEND_FIRST,
    CLS_TOO_LONG,
    CLS_SET,
    CLS_ERASE_PAGE,
    CLS_ERASE_ALL,
    CLS_REJECT
  } cls_e;

  typedef enum logic [1:0] {
    BK_HEAD,
    BK_LINK,
    BK_DATA
  } bk_state_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic              region;
    logic [WORD_W-1:0] word_value;
    logic [ADDR_W-1:0] target_address;
    logic [LEN_W-1:0]  record_words;
    logic              first_of_record;
  } item_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] flash_address;
    logic [WORD_W-1:0] flash_data;
    logic [KEY_W-1:0]  write_key;
    logic [1:0]        fault;
    logic              last;
  } res_t;

  typedef struct packed {
    cls_e              cls;
    logic              region;
    logic [WORD_W-1:0] word_value;
    logic [ADDR_W-1:0] address;
    logic [END_W-1:0]  tgt_end;
    logic [NEED_W-1:0] need8;
    fault_e            fault;
  } entry_t;

endpackage

// ----- sv/chained_page_flash_appender.sv -----
// ----------------------------------------------------------------------------
// Chained page flash appender: top level
// Appends word records to a dictionary region and a code region of flash,
// chaining 1 KiB pages, and issues page-erase and mass-erase commands.
// ----------------------------------------------------------------------------
// Each input transfer yields one output transfer, except an append that starts
// a record which no longer fits in its page and flash has room to roll over:
// that yields three, namely an end-of-page marker, a link word holding the
// new page address and the data word itself, the last of which carries
// last = 1. The front end takes one input transfer per cycle unless a full
// queue holds its register, and classifies it; a four-entry queue decouples
// it from the back end, which owns both write pointers and emits one result
// per cycle into the output register while the output is not stalled. A page
// rollover holds the back end in its link and data states before it pops the
// item. The first result passes the front register and the queue before the
// output register loads it. There is no clearing pass after reset. The write
// key is chosen by key_mode, written through cfg_we_i and cfg_wdata_i; the
// user must write it only while the block is idle, which it does not enforce.
module chained_page_flash_appender #(
  parameter int unsigned PAGE_BYTES  = cpfa_pkg::PAGE_BYTES_DEF,
  parameter int unsigned FLASH_BYTES = cpfa_pkg::FLASH_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cpfa_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cpfa_pkg::res_t  out_item_o
);
  import cpfa_pkg::*;

  logic   key_mode_q;
  logic   push;
  logic   pop;
  logic   fifo_full;
  logic   fifo_empty;
  entry_t push_entry;
  entry_t head_entry;

  // Key selection register; zero after reset selects the first key.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      key_mode_q <= cfg_wdata_i;
    end
  end

  // Front end: accepts transfers, validates targets, finds the target's page.
  cpfa_front #(
    .PAGE_BYTES (PAGE_BYTES),
    .FLASH_BYTES(FLASH_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .fifo_full_i(fifo_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Queue of classified items, so the front end keeps taking transfers while
  // the back end works through a rollover or waits on a stalled output.
  cpfa_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_entry),
    .pop_i  (pop),
    .full_o (fifo_full),
    .empty_o(fifo_empty),
    .rdata_o(head_entry)
  );

  // Back end: region pointers, fit and rollover decision, output register.
  cpfa_back #(
    .PAGE_BYTES (PAGE_BYTES),
    .FLASH_BYTES(FLASH_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_mode_i (key_mode_q),
    .empty_i    (fifo_empty),
    .head_i     (head_entry),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

// ----- sv/cpfa_front.sv -----
// ----------------------------------------------------------------------------
// Chained page flash appender: front end
// Accepts items, checks targets and record lengths, and finds a target's page.
// ----------------------------------------------------------------------------
module cpfa_front #(
  parameter int unsigned PAGE_BYTES  = cpfa_pkg::PAGE_BYTES_DEF,
  parameter int unsigned FLASH_BYTES = cpfa_pkg::FLASH_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cpfa_pkg::item_t  in_item_i,
  input  logic             fifo_full_i,
  output logic             push_o,
  output cpfa_pkg::entry_t entry_o
);
  import cpfa_pkg::*;

  // Page number by multiplication with a rounded-up reciprocal, exact for
  // every address of ADDR_W bits.
  localparam int unsigned PAGE_LOG = $clog2(PAGE_BYTES);
  localparam int unsigned SHIFT    = ADDR_W + PAGE_LOG;
  localparam int unsigned RECIP_W  = ADDR_W + 2;
  localparam int unsigned PROD_W   = ADDR_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
  localparam logic [RECIP_W-1:0] RECIP_V   = RECIP_W'(RECIP);
  localparam logic [END_W-1:0]   PAGE_V    = END_W'(PAGE_BYTES);
  localparam logic [CMP_W-1:0]   PAGE_CMP  = CMP_W'(PAGE_BYTES);
  localparam logic [CMP_W-1:0]   FLASH_CMP = CMP_W'(FLASH_BYTES);

  logic              s1_valid_q, s1_valid_d;
  item_t             s1_item_q;
  logic [ADDR_W-1:0] quot_q, quot_d;
  logic [PROD_W-1:0] prod;
  logic              accept;
  logic [END_W-1:0]  base;
  logic [NEED_W-1:0] need8;
  logic              unaligned;
  logic              beyond;

  assign in_stall_o = s1_valid_q & fifo_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = s1_valid_q & ~fifo_full_i;
  assign s1_valid_d = accept | (s1_valid_q & fifo_full_i);

  assign prod   = PROD_W'(in_item_i.target_address) * PROD_W'(RECIP_V);
  assign quot_d = ADDR_W'(prod >> SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item_i;
      quot_q    <= quot_d;
    end
  end

  always_comb begin
    base      = END_W'(quot_q) * PAGE_V;
    need8     = NEED_W'({s1_item_q.record_words, 2'b00}) + NEED_W'(8);
    unaligned = |s1_item_q.target_address[1:0];
    beyond    = CMP_W'(s1_item_q.target_address) >= FLASH_CMP;

    entry_o.cls        = CLS_REJECT;
    entry_o.region     = s1_item_q.region;
    entry_o.word_value = s1_item_q.word_value;
    entry_o.address    = s1_item_q.target_address;
    entry_o.tgt_end    = base + PAGE_V;
    entry_o.need8      = need8;
    entry_o.fault      = FLT_NONE;

    unique case (s1_item_q.operation)
      OP_APPEND: begin
        if (!s1_item_q.first_of_record) begin
          entry_o.cls = CLS_APPEND;
        end else if (CMP_W'(need8) > PAGE_CMP) begin
          entry_o.cls = CLS_TOO_LONG;
        end else begin
          entry_o.cls = CLS_APPEND_FIRST;
        end
      end
      OP_SET_PTR: begin
        if (unaligned) begin
          entry_o.fault = FLT_UNALIGNED;
        end else if (beyond) begin
          entry_o.fault = FLT_FULL;
        end else begin
          entry_o.cls = CLS_SET;
        end
      end
      OP_ERASE_PAGE: begin
        if (unaligned) begin
          entry_o.fault = FLT_UNALIGNED;
        end else if (beyond) begin
          entry_o.fault = FLT_FULL;
        end else begin
          entry_o.cls = CLS_ERASE_PAGE;
        end
      end
      OP_ERASE_ALL: begin
        entry_o.cls = CLS_ERASE_ALL;
      end
    endcase
  end

endmodule

// ----- sv/cpfa_fifo.sv -----
// ----------------------------------------------------------------------------
// Chained page flash appender: item queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module cpfa_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cpfa_pkg::entry_t wdata_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output cpfa_pkg::entry_t rdata_o
);
  import cpfa_pkg::*;

  entry_t             store_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   count_q, count_d;

  assign full_o  = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign rdata_o = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- sv/cpfa_back.sv -----
// ----------------------------------------------------------------------------
// Chained page flash appender: back end
// Keeps both region pointers, makes the page rollover decision and emits
// flash commands through the output register.
// ----------------------------------------------------------------------------
module cpfa_back #(
  parameter int unsigned PAGE_BYTES  = cpfa_pkg::PAGE_BYTES_DEF,
  parameter int unsigned FLASH_BYTES = cpfa_pkg::FLASH_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             key_mode_i,
  input  logic             empty_i,
  input  cpfa_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cpfa_pkg::res_t   out_item_o
);
  import cpfa_pkg::*;

  localparam int unsigned DICT_END_RST =
    (int'(DICT_PTR_RST) / PAGE_BYTES) * PAGE_BYTES + PAGE_BYTES;
  localparam int unsigned CODE_END_RST =
    (int'(CODE_PTR_RST) / PAGE_BYTES) * PAGE_BYTES + PAGE_BYTES;
  localparam logic [END_W-1:0] PAGE_V    = END_W'(PAGE_BYTES);
  localparam logic [CMP_W-1:0] PAGE_CMP  = CMP_W'(PAGE_BYTES);
  localparam logic [CMP_W-1:0] FLASH_CMP = CMP_W'(FLASH_BYTES);

  bk_state_e         state_q, state_d;
  logic [ADDR_W-1:0] ptr_q [2];
  logic [ADDR_W-1:0] ptr_d [2];
  logic [END_W-1:0]  end_q [2];
  logic [END_W-1:0]  end_d [2];
  logic [ADDR_W-1:0] mark_q, mark_d;
  logic [ADDR_W-1:0] np_q, np_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;

  logic              out_ready;
  logic [ADDR_W-1:0] p;
  logic [END_W-1:0]  pe;
  logic [END_W-1:0]  np;
  logic [CMP_W-1:0]  p4;
  logic              no_fit;
  logic              full_roll;
  logic              full_plain;

  function automatic res_t make_res(cmd_e cmd, logic [ADDR_W-1:0] addr,
                                    logic [WORD_W-1:0] data, fault_e flt,
                                    logic lst, logic kmode);
    res_t r;
    r.command       = cmd;
    r.flash_address = addr;
    r.flash_data    = data;
    r.write_key     = (cmd == CMD_NONE) ? '0 : (kmode ? KEY_B : KEY_A);
    r.fault         = flt;
    r.last          = lst;
    return r;
  endfunction

  assign out_ready   = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

  always_comb begin
    p          = ptr_q[head_i.region];
    pe         = end_q[head_i.region];
    np         = (end_q[REG_DICT] > end_q[REG_CODE]) ? end_q[REG_DICT] : end_q[REG_CODE];
    p4         = CMP_W'(p) + CMP_W'(4);
    no_fit     = CMP_W'(p) + CMP_W'(head_i.need8) > CMP_W'(pe);
    full_roll  = (CMP_W'(p) + CMP_W'(8) > FLASH_CMP) ||
                 (CMP_W'(np) + PAGE_CMP > FLASH_CMP);
    full_plain = p4 > FLASH_CMP;

    state_d     = state_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    mark_d      = mark_q;
    np_d        = np_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & out_stall_i;
    pop_o       = 1'b0;

    unique case (state_q)
      BK_HEAD: begin
        if (!empty_i && out_ready) begin
          out_valid_d = 1'b1;
          pop_o       = 1'b1;
          unique case (head_i.cls)
            CLS_REJECT: begin
              res_d = make_res(CMD_NONE, head_i.address, '0, head_i.fault, 1'b1, key_mode_i);
            end
            CLS_SET: begin
              res_d = make_res(CMD_NONE, head_i.address, '0, FLT_NONE, 1'b1, key_mode_i);
              ptr_d[head_i.region] = head_i.address;
              end_d[head_i.region] = head_i.tgt_end;
            end
            CLS_ERASE_PAGE: begin
              res_d = make_res(CMD_ERASE_PAGE, head_i.address, '0, FLT_NONE, 1'b1,
                               key_mode_i);
            end
            CLS_ERASE_ALL: begin
              res_d = make_res(CMD_ERASE_ALL, '0, '0, FLT_NONE, 1'b1, key_mode_i);
            end
            CLS_TOO_LONG: begin
              res_d = make_res(CMD_NONE, p, '0, FLT_TOO_LONG, 1'b1, key_mode_i);
            end
            CLS_APPEND, CLS_APPEND_FIRST: begin
              if (head_i.cls == CLS_APPEND_FIRST && no_fit) begin
                if (full_roll) begin
                  res_d = make_res(CMD_NONE, p, '0, FLT_FULL, 1'b1, key_mode_i);
                end else begin
                  // Page rollover: marker now, link and data word follow.
                  res_d   = make_res(CMD_PROGRAM, p, END_MARK, FLT_NONE, 1'b0, key_mode_i);
                  pop_o   = 1'b0;
                  state_d = BK_LINK;
                  mark_d  = p;
                  np_d    = ADDR_W'(np);
                  ptr_d[head_i.region] = ADDR_W'(np + END_W'(4));
                  end_d[head_i.region] = np + PAGE_V;
                end
              end else if (full_plain) begin
                res_d = make_res(CMD_NONE, p, '0, FLT_FULL, 1'b1, key_mode_i);
              end else begin
                res_d = make_res(CMD_PROGRAM, p, head_i.word_value, FLT_NONE, 1'b1,
                                 key_mode_i);
                if (p4[ADDR_W]) begin
                  // Address space wraps to the bottom page.
                  ptr_d[head_i.region] = '0;
                  end_d[head_i.region] = PAGE_V;
                end else begin
                  ptr_d[head_i.region] = p4[ADDR_W-1:0];
                  if (END_W'(p4) >= pe) begin
                    end_d[head_i.region] = pe + PAGE_V;
                  end
                end
              end
            end
            default: begin
              res_d = make_res(CMD_NONE, head_i.address, '0, head_i.fault, 1'b1, key_mode_i);
            end
          endcase
        end
      end
      BK_LINK: begin
        if (out_ready) begin
          out_valid_d = 1'b1;
          res_d   = make_res(CMD_PROGRAM, mark_q + ADDR_W'(4), WORD_W'(np_q), FLT_NONE,
                             1'b0, key_mode_i);
          state_d = BK_DATA;
        end
      end
      BK_DATA: begin
        if (out_ready) begin
          out_valid_d = 1'b1;
          res_d   = make_res(CMD_PROGRAM, np_q, head_i.word_value, FLT_NONE, 1'b1,
                             key_mode_i);
          pop_o   = 1'b1;
          state_d = BK_HEAD;
        end
      end
      default: begin
        state_d = BK_HEAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= BK_HEAD;
      out_valid_q     <= 1'b0;
      ptr_q[REG_DICT] <= DICT_PTR_RST;
      ptr_q[REG_CODE] <= CODE_PTR_RST;
      end_q[REG_DICT] <= END_W'(DICT_END_RST);
      end_q[REG_CODE] <= END_W'(CODE_END_RST);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ptr_q       <= ptr_d;
      end_q       <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    mark_q <= mark_d;
    np_q   <= np_d;
  end

endmodule

// ----- sv/cpfa_checker.sv -----
// ----------------------------------------------------------------------------
// Chained page flash appender: port checker
// Concurrent checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "chained_page_flash_appender_defines.svh"

module cpfa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input cpfa_pkg::res_t out_item_o
);
  import cpfa_pkg::*;

  // A result held back by the receiver stays offered and unchanged.
  `CPFA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_item_o), "stalled result changed or was dropped")

  // Results without a flash action carry neither key nor data.
  `CPFA_ASSERT_IMP(a_none_quiet, clk_i, rst_ni,
    out_valid_o && out_item_o.command == CMD_NONE,
    out_item_o.write_key == '0 && out_item_o.flash_data == '0,
    "key or data present on a result without flash action")

  // A mass erase is a single, fault-free result at address zero.
  `CPFA_ASSERT_IMP(a_erase_all, clk_i, rst_ni,
    out_valid_o && out_item_o.command == CMD_ERASE_ALL,
    out_item_o.flash_address == '0 && out_item_o.last && out_item_o.fault == FLT_NONE,
    "malformed mass erase")

  // Within a rollover the next program result follows in the very next cycle.
  `CPFA_ASSERT_NXT(a_roll_cont, clk_i, rst_ni,
    out_valid_o && !out_stall_i && !out_item_o.last,
    out_valid_o && out_item_o.command == CMD_PROGRAM && out_item_o.fault == FLT_NONE,
    "rollover sequence broken")

endmodule

bind chained_page_flash_appender cpfa_checker u_cpfa_checker (.*);

// ----- bench/chained_page_flash_appender_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chained page flash appender: testbench
// Drives appends, pointer sets and erases into the appender and checks every
// result against a typed row or a predictor of two write pointers and the key.
// ----------------------------------------------------------------------------
module chained_page_flash_appender_tb;
  import cpfa_pkg::*;

  localparam int unsigned PAGE          = PAGE_BYTES_DEF;
  localparam int unsigned FLASH         = FLASH_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned PHASE_ITEMS   = 80;

  // Per phase: how often the sender idles and the receiver stalls, in percent.
  localparam int unsigned GAP_PCT   [PHASES] = '{0, 52, 0, 14, 0};
  localparam int unsigned STALL_PCT [PHASES] = '{0, 0, 52, 14, 0};

  // One row of the directed table. Where typed is set, res is the result
  // written out by hand; otherwise the predictor supplies what is due.
  typedef struct packed {
    item_t it;
    logic  typed;
    res_t  res;
  } dir_row_t;

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  cfg_we    = 1'b0;
  logic  cfg_wdata = 1'b0;
  logic  in_valid  = 1'b0;
  item_t in_item   = '0;
  logic  in_stall;
  logic  out_valid;
  logic  out_stall = 1'b0;
  res_t  out_item;

  int unsigned send_gap_pct   = 0;
  int unsigned stall_pct      = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned accepted_items = 0;
  int unsigned cycles         = 0;
  int unsigned errors         = 0;

  // Predictor state: one write pointer per region and the selected key.
  logic [ADDR_W-1:0] wr_ptr [2];
  logic              key_sel;

  // Flash operations still owed by the block, oldest first.
  res_t     ops_due [$];
  res_t     due_op;
  dir_row_t dir_rows [$];

  chained_page_flash_appender DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic item_t item_of(op_e op, region_e r, logic [WORD_W-1:0] w,
                                    int unsigned tgt, int unsigned len,
                                    int unsigned first);
    item_t it;
    it.operation       = op;
    it.region          = r;
    it.word_value      = w;
    it.target_address  = ADDR_W'(tgt);
    it.record_words    = LEN_W'(len);
    it.first_of_record = (first != 0);
    return it;
  endfunction

  function automatic res_t result_of(cmd_e cmd, int unsigned addr, logic [WORD_W-1:0] data,
                                     logic [KEY_W-1:0] key, fault_e flt);
    res_t r;
    r.command       = cmd;
    r.flash_address = ADDR_W'(addr);
    r.flash_data    = data;
    r.write_key     = key;
    r.fault         = flt;
    r.last          = 1'b1;
    return r;
  endfunction

  // Records one flash operation that the block owes. The key travels only
  // with real flash commands.
  function automatic void add_op(cmd_e cmd, int unsigned addr, logic [WORD_W-1:0] data,
                                 fault_e flt, logic fin);
    res_t r;
    r.command       = cmd;
    r.flash_address = ADDR_W'(addr);
    r.flash_data    = data;
    r.write_key     = (cmd == CMD_NONE) ? '0 : (key_sel ? KEY_B : KEY_A);
    r.fault         = flt;
    r.last          = fin;
    ops_due.push_back(r);
  endfunction

  // Works out the flash operations that one accepted item causes and moves
  // the predicted pointers on.
  function automatic void queue_flash_ops(item_t it);
    int unsigned p, tgt, need, base, pd, pc, np;
    bit          done;
    p    = wr_ptr[it.region];
    tgt  = it.target_address;
    done = 1'b0;
    case (op_e'(it.operation))
      OP_SET_PTR, OP_ERASE_PAGE: begin
        if (it.target_address[1:0] != 2'b00) begin
          add_op(CMD_NONE, tgt, '0, FLT_UNALIGNED, 1'b1);
        end else if (tgt >= FLASH) begin
          add_op(CMD_NONE, tgt, '0, FLT_FULL, 1'b1);
        end else if (op_e'(it.operation) == OP_SET_PTR) begin
          wr_ptr[it.region] = ADDR_W'(tgt);
          add_op(CMD_NONE, tgt, '0, FLT_NONE, 1'b1);
        end else begin
          add_op(CMD_ERASE_PAGE, tgt, '0, FLT_NONE, 1'b1);
        end
      end
      OP_ERASE_ALL: begin
        add_op(CMD_ERASE_ALL, 0, '0, FLT_NONE, 1'b1);
      end
      OP_APPEND: begin
        if (it.first_of_record) begin
          need = int'(it.record_words) * 4;
          base = p - p % PAGE;
          if (need + 8 > PAGE) begin
            add_op(CMD_NONE, p, '0, FLT_TOO_LONG, 1'b1);
            done = 1'b1;
          end else if (p + need + 8 > base + PAGE) begin
            // Rollover: the fresh page sits one page above the higher of the
            // two regions' current pages.
            pd = wr_ptr[REG_DICT] - wr_ptr[REG_DICT] % PAGE;
            pc = wr_ptr[REG_CODE] - wr_ptr[REG_CODE] % PAGE;
            np = ((pd > pc) ? pd : pc) + PAGE;
            if (p + 8 > FLASH || np + PAGE > FLASH) begin
              add_op(CMD_NONE, p, '0, FLT_FULL, 1'b1);
            end else begin
              add_op(CMD_PROGRAM, p, END_MARK, FLT_NONE, 1'b0);
              add_op(CMD_PROGRAM, p + 4, np, FLT_NONE, 1'b0);
              add_op(CMD_PROGRAM, np, it.word_value, FLT_NONE, 1'b1);
              wr_ptr[it.region] = ADDR_W'(np + 4);
            end
            done = 1'b1;
          end
        end
        if (!done) begin
          if (p + 4 > FLASH) begin
            add_op(CMD_NONE, p, '0, FLT_FULL, 1'b1);
          end else begin
            add_op(CMD_PROGRAM, p, it.word_value, FLT_NONE, 1'b1);
            wr_ptr[it.region] = ADDR_W'(p + 4);
          end
        end
      end
    endcase
  endfunction

  function automatic void compare_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Offers one item, idling beforehand at the phase's rate, and waits for the
  // transfer. Valid is left high so that back-to-back items need no gap.
  task automatic offer(item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    queue_flash_ops(it);
    accepted_items++;
  endtask

  // Stops offering and waits until every owed operation has come out.
  task automatic settle(int unsigned extra);
    in_valid <= 1'b0;
    while (ops_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_key(logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    key_sel = v;
    cfg_we <= 1'b0;
  endtask

  // Random traffic. Most of it is well-formed records; pointer sets close to
  // the end of a page make rollovers common, and a share of noise covers the
  // fault cases and erases.
  task automatic run_random(int unsigned budget, bit pause_mid);
    int unsigned stop_at, half_at, pick, page, tgt, len, words;
    region_e     r;
    bit          paused;
    stop_at = accepted_items + budget;
    half_at = accepted_items + budget / 2;
    paused  = 1'b0;
    while (accepted_items < stop_at) begin
      pick = $urandom_range(99);
      r    = region_e'($urandom_range(1));
      if (pick < 12) begin
        case ($urandom_range(2))
          0:       tgt = $urandom_range(0, 19'h7FFFF);
          1:       tgt = 4 * $urandom_range(0, FLASH / 4 - 1);
          default: tgt = 4 * $urandom_range(FLASH / 4, 19'h1FFFF);
        endcase
        offer(item_of(op_e'($urandom_range(3)), r, $urandom, tgt,
                      $urandom_range(0, 256), $urandom_range(1)));
      end else if (pick < 30) begin
        page = ($urandom_range(9) == 0) ? $urandom_range(316, 319) : $urandom_range(0, 319);
        tgt  = page * PAGE + PAGE - 4 * $urandom_range(1, 16);
        offer(item_of(OP_SET_PTR, r, $urandom, tgt, $urandom_range(0, 256),
                      $urandom_range(1)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 60)      len = $urandom_range(1, 8);
        else if (pick < 85) len = $urandom_range(9, 64);
        else if (pick < 93) len = $urandom_range(200, 254);
        else if (pick < 97) len = $urandom_range(255, 256);
        else                len = 0;
        // Long records are cut short so that one record does not swallow
        // the whole phase.
        words = (len == 0) ? 1 : ((len > 6) ? $urandom_range(1, 6) : len);
        for (int k = 0; k < words; k++) begin
          offer(item_of(OP_APPEND, r, $urandom, $urandom_range(0, 19'h7FFFF), len, k == 0));
        end
      end
      if (pause_mid && !paused && accepted_items >= half_at) begin
        settle(0);
        paused = 1'b1;
      end
    end
  endtask

  // Receiver: stalls at the phase's rate, or holds off for a long stretch
  // whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every output transfer is matched against the oldest owed operation.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (ops_due.size() == 0) begin
        $display("%0t ns: result 0x%0h arrived with nothing outstanding", $time, out_item);
        errors++;
      end else begin
        due_op = ops_due.pop_front();
        compare_field("command", due_op.command, out_item.command);
        compare_field("flash_address", due_op.flash_address, out_item.flash_address);
        compare_field("flash_data", due_op.flash_data, out_item.flash_data);
        compare_field("write_key", due_op.write_key, out_item.write_key);
        compare_field("fault", due_op.fault, out_item.fault);
        compare_field("last", due_op.last, out_item.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t ns: timed out with %0d results outstanding", $time, ops_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    wr_ptr[REG_DICT] = DICT_PTR_RST;
    wr_ptr[REG_CODE] = CODE_PTR_RST;
    key_sel          = 1'b0;

    // Directed part, run straight after reset with the default key.
    // First words with room to spare, the zero-length record among them.
    dir_rows.push_back({item_of(OP_APPEND, REG_DICT, 32'hFFFF_FFFF, 0, 1, 1), 1'b1,
                        result_of(CMD_PROGRAM, 19'h0B600, 32'hFFFF_FFFF, KEY_A, FLT_NONE)});
    dir_rows.push_back({item_of(OP_APPEND, REG_CODE, 32'h0, 19'h7FFFF, 0, 1), 1'b1,
                        result_of(CMD_PROGRAM, 19'h0BA00, 32'h0, KEY_A, FLT_NONE)});
    // Records longer than a page can ever hold.
    dir_rows.push_back({item_of(OP_APPEND, REG_DICT, 32'h1234_5678, 0, 256, 1), 1'b1,
                        result_of(CMD_NONE, 19'h0B604, 32'h0, '0, FLT_TOO_LONG)});
    dir_rows.push_back({item_of(OP_APPEND, REG_CODE, 32'h8765_4321, 0, 255, 1), 1'b1,
                        result_of(CMD_NONE, 19'h0BA04, 32'h0, '0, FLT_TOO_LONG)});
    // The longest record that fits a page forces a rollover here.
    dir_rows.push_back({item_of(OP_APPEND, REG_DICT, 32'hA5A5_5A5A, 0, 254, 1), 1'b0, res_t'(0)});
    dir_rows.push_back({item_of(OP_APPEND, REG_DICT, 32'h0000_0001, 0, 254, 0), 1'b0, res_t'(0)});
    // Bad pointer sets, page erases with good and bad targets, a mass erase.
    dir_rows.push_back({item_of(OP_SET_PTR, REG_DICT, 32'h0, 19'h00003, 1, 0), 1'b1,
                        result_of(CMD_NONE, 19'h00003, 32'h0, '0, FLT_UNALIGNED)});
    dir_rows.push_back({item_of(OP_SET_PTR, REG_CODE, 32'h0, 19'h7FFFC, 1, 0), 1'b1,
                        result_of(CMD_NONE, 19'h7FFFC, 32'h0, '0, FLT_FULL)});
    dir_rows.push_back({item_of(OP_SET_PTR, REG_DICT, 32'h0, 19'h7FFFF, 1, 0), 1'b1,
                        result_of(CMD_NONE, 19'h7FFFF, 32'h0, '0, FLT_UNALIGNED)});
    dir_rows.push_back({item_of(OP_ERASE_PAGE, REG_DICT, 32'h0, 19'h00000, 1, 0), 1'b1,
                        result_of(CMD_ERASE_PAGE, 19'h00000, 32'h0, KEY_A, FLT_NONE)});
    dir_rows.push_back({item_of(OP_ERASE_PAGE, REG_CODE, 32'h0, 19'h4FFFC, 1, 0), 1'b1,
                        result_of(CMD_ERASE_PAGE, 19'h4FFFC, 32'h0, KEY_A, FLT_NONE)});
    dir_rows.push_back({item_of(OP_ERASE_PAGE, REG_DICT, 32'h0, 19'h50000, 1, 0), 1'b1,
                        result_of(CMD_NONE, 19'h50000, 32'h0, '0, FLT_FULL)});
    dir_rows.push_back({item_of(OP_ERASE_PAGE, REG_DICT, 32'h0, 19'h00002, 1, 0), 1'b1,
                        result_of(CMD_NONE, 19'h00002, 32'h0, '0, FLT_UNALIGNED)});
    dir_rows.push_back({item_of(OP_ERASE_ALL, REG_CODE, 32'hFFFF_FFFF, 19'h7FFFF, 256, 1), 1'b1,
                        result_of(CMD_ERASE_ALL, 19'h00000, 32'h0, KEY_A, FLT_NONE)});
    // The last word of flash, then appends past its end.
    dir_rows.push_back({item_of(OP_SET_PTR, REG_DICT, 32'h0, 19'h4FFFC, 1, 0), 1'b1,
                        result_of(CMD_NONE, 19'h4FFFC, 32'h0, '0, FLT_NONE)});
    dir_rows.push_back({item_of(OP_APPEND, REG_DICT, 32'hDEAD_BEEF, 0, 1, 0), 1'b1,
                        result_of(CMD_PROGRAM, 19'h4FFFC, 32'hDEAD_BEEF, KEY_A, FLT_NONE)});
    dir_rows.push_back({item_of(OP_APPEND, REG_DICT, 32'h0000_FFFF, 0, 1, 0), 1'b1,
                        result_of(CMD_NONE, 19'h50000, 32'h0, '0, FLT_FULL)});
    dir_rows.push_back({item_of(OP_APPEND, REG_DICT, 32'hFFFF_0000, 0, 1, 1), 1'b1,
                        result_of(CMD_NONE, 19'h50000, 32'h0, '0, FLT_FULL)});
    // A rollover in the top page has nowhere to go.
    dir_rows.push_back({item_of(OP_SET_PTR, REG_DICT, 32'h0, 19'h4FFF8, 1, 0), 1'b1,
                        result_of(CMD_NONE, 19'h4FFF8, 32'h0, '0, FLT_NONE)});
    dir_rows.push_back({item_of(OP_APPEND, REG_DICT, 32'h5555_AAAA, 0, 2, 1), 1'b1,
                        result_of(CMD_NONE, 19'h4FFF8, 32'h0, '0, FLT_FULL)});
    // Low pointers: an exact fit, another exact fit, then a rollover.
    dir_rows.push_back({item_of(OP_SET_PTR, REG_DICT, 32'h0, 19'h02000, 1, 0), 1'b1,
                        result_of(CMD_NONE, 19'h02000, 32'h0, '0, FLT_NONE)});
    dir_rows.push_back({item_of(OP_SET_PTR, REG_CODE, 32'h0, 19'h00FF0, 1, 0), 1'b1,
                        result_of(CMD_NONE, 19'h00FF0, 32'h0, '0, FLT_NONE)});
    dir_rows.push_back({item_of(OP_APPEND, REG_CODE, 32'h0BAD_F00D, 0, 2, 1), 1'b0, res_t'(0)});
    dir_rows.push_back({item_of(OP_APPEND, REG_CODE, 32'hCAFE_0001, 0, 1, 1), 1'b0, res_t'(0)});
    dir_rows.push_back({item_of(OP_APPEND, REG_CODE, 32'hCAFE_0002, 0, 1, 1), 1'b0, res_t'(0)});
    dir_rows.push_back({item_of(OP_APPEND, REG_CODE, 32'hCAFE_0003, 0, 1, 0), 1'b0, res_t'(0)});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hand-written results replace what the predictor worked out for that
    // row; the predictor still moves its pointers on.
    foreach (dir_rows[i]) begin
      offer(dir_rows[i].it);
      if (dir_rows[i].typed) ops_due[ops_due.size() - 1] = dir_rows[i].res;
    end

    // Random phases. The key changes between phases once the block is idle.
    // The second phase stops halfway until everything owed has come out; the
    // last one opens with a long receiver hold-off while items keep coming,
    // which fills the block until it stalls its input.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle(SETTLE_CYCLES);
      write_key(ph % 2 == 0);
      send_gap_pct = GAP_PCT[ph];
      stall_pct    = STALL_PCT[ph];
      if (ph == PHASES - 1) hold_req++;
      run_random(PHASE_ITEMS, ph == 1);
    end

    settle(SETTLE_CYCLES);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- chained_page_flash_appender.f -----
+incdir+sv
sv/cpfa_pkg.sv
sv/cpfa_front.sv
sv/cpfa_fifo.sv
sv/cpfa_back.sv
sv/chained_page_flash_appender.sv
sv/cpfa_checker.sv
bench/chained_page_flash_appender_tb.sv
